FILE: sv/sht_pkg.sv
`timescale 1ns / 1ps
package sht_pkg;

  localparam int NODES        = 64;
  localparam int IDX_W        = 6;
  localparam int POS_W        = 24;
  localparam int DIFF_W       = POS_W + 1;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int INTV_W       = 16;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int SPEED_W      = 24;
  localparam int HEAD_W       = 13;
  localparam int CORDIC_STEPS = 16;
  localparam int CX_W         = 58;
  localparam int Z_W          = 31;
  localparam int CNT_W        = 6;

  localparam logic [HEAD_W-1:0]  HEADING_FULL = 13'd5760;
  localparam logic signed [Z_W-1:0] DEG180 = 31'sd188743680;
  localparam logic signed [Z_W-1:0] DEG360 = 31'sd377487360;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_SQX  = 8'b0000_0100,
    S_SQY  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_SQRT = 8'b0010_0000,
    S_CORD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] i);
    logic signed [Z_W-1:0] t;
    begin
      unique case (i)
        5'd0:    t = 31'sd47185920;
        5'd1:    t = 31'sd27855475;
        5'd2:    t = 31'sd14718068;
        5'd3:    t = 31'sd7471121;
        5'd4:    t = 31'sd3750058;
        5'd5:    t = 31'sd1876857;
        5'd6:    t = 31'sd938658;
        5'd7:    t = 31'sd469357;
        5'd8:    t = 31'sd234682;
        5'd9:    t = 31'sd117342;
        5'd10:   t = 31'sd58671;
        5'd11:   t = 31'sd29335;
        5'd12:   t = 31'sd14668;
        5'd13:   t = 31'sd7334;
        5'd14:   t = 31'sd3667;
        5'd15:   t = 31'sd1833;
        5'd16:   t = 31'sd917;
        5'd17:   t = 31'sd458;
        5'd18:   t = 31'sd229;
        5'd19:   t = 31'sd115;
        5'd20:   t = 31'sd57;
        5'd21:   t = 31'sd29;
        5'd22:   t = 31'sd14;
        5'd23:   t = 31'sd7;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

FILE: sv/sht_ram.sv
`timescale 1ns / 1ps
module sht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/speed_heading_tracker.sv
`timescale 1ns / 1ps
// Motion tracker for 64 nodes. Each request carries a node index and the
// node's position; the first request for a node only stores the position
// (updated=0, speed and heading 0). Later requests give speed =
// floor(sqrt((dx^2+dy^2)/sample_interval)), saturated to 24 bits, and the
// heading atan2(dy,dx) in 1/16 degree from a 16-step vectoring cordic
// (0 when speed is 0). One request is in flight at a time: a moving node
// goes from accept to result through position load, one multiplier used
// twice, a one-bit-per-cycle divider over 50 quotient bits, a
// two-bits-per-cycle root over 25 result bits, cordic setup and 16
// rotations, and output load; a first sample or a zero speed skips the
// later phases. The result sits in an output register, so the next request
// may be taken while it waits. sample_interval 0 acts as 1; write it only
// while idle.
module speed_heading_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,      // sample_interval
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,       // node_index[5:0], pos_x[29:6], pos_y[53:30]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata        // out_index[5:0], speed[29:6], heading[42:30],
                                     // updated[43]
);
  import sht_pkg::*;

  state_t state;
  logic [INTV_W-1:0] sample_interval;
  logic [NODES-1:0]  seen;
  logic [CNT_W-1:0]  cnt;

  // request capture
  logic [IDX_W-1:0]        idx;
  logic signed [POS_W-1:0] px, py;
  logic signed [DIFF_W-1:0] dx, dy;
  logic                     first;

  // shared datapath registers
  logic [SQ_W-1:0]    d2;       // squared distance, then quotient
  logic [INTV_W-1:0]  rem;      // division remainder
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W+1:0]  srem;     // root remainder
  logic signed [CX_W-1:0] cx, cy;
  logic signed [Z_W-1:0]  cz;
  logic [SPEED_W-1:0] spd;

  logic [2*POS_W-1:0] ram_rdata;
  logic               ram_we;
  logic accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign ram_we   = (state == S_LOAD);

  sht_ram #(.WIDTH(2*POS_W), .DEPTH(NODES)) u_pos (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({py, px}),
    .raddr (s_tdata[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // previous position and differences
  logic signed [POS_W-1:0] lx, ly;
  assign lx = ram_rdata[POS_W-1:0];
  assign ly = ram_rdata[2*POS_W-1:POS_W];

  // one multiplier for both squares
  logic signed [DIFF_W-1:0] mop;
  logic signed [SQ_W-1:0]   mprod;
  assign mop   = (state == S_SQX) ? dx : dy;
  assign mprod = mop * mop;

  // divider step
  logic [INTV_W:0]   dshift;
  logic [INTV_W:0]   divisor;
  logic              dbit;
  assign divisor = (sample_interval == '0) ? (INTV_W+1)'(1) : {1'b0, sample_interval};
  assign dshift  = {rem, d2[SQ_W-1]};
  assign dbit    = (dshift >= divisor);

  // root step
  logic [ROOT_W+1:0] rshift, rtrial;
  logic              rbit;
  assign rshift = {srem[ROOT_W-1:0], d2[SQ_W-1:SQ_W-2]};
  assign rtrial = {root, 2'b01};
  assign rbit   = (rshift >= rtrial);

  // cordic step
  logic signed [CX_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  tab;
  assign xs  = cx >>> cnt[4:0];
  assign ys  = cy >>> cnt[4:0];
  assign tab = atan_tab(cnt[4:0]);

  // cordic start vector, folded into the right half plane
  logic signed [CX_W-1:0] x0, y0;
  assign x0 = {{(CX_W-DIFF_W-30){dx[DIFF_W-1]}}, dx, 30'b0};
  assign y0 = {{(CX_W-DIFF_W-30){dy[DIFF_W-1]}}, dy, 30'b0};

  // angle to 1/16 degree with rounding and wrap
  logic signed [Z_W-1:0] zpos, zsum;
  logic [HEAD_W-1:0]     hraw, hdg;
  assign zpos = (cz < 0) ? cz + DEG360 : cz;
  assign zsum = zpos + Z_W'(32768);
  assign hraw = zsum[HEAD_W+15:16];
  assign hdg  = (hraw >= HEADING_FULL) ? hraw - HEADING_FULL : hraw;

  logic [SPEED_W-1:0] root_sat;
  assign root_sat = root[ROOT_W-1] ? '1 : root[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= INTV_W'(1);
    end else if (cfg_we) begin
      sample_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      seen     <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a result loaded in S_DONE takes over the slot being emptied
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx   <= s_tdata[IDX_W-1:0];
            px    <= s_tdata[IDX_W+POS_W-1:IDX_W];
            py    <= s_tdata[IDX_W+2*POS_W-1:IDX_W+POS_W];
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          first     <= !seen[idx];
          seen[idx] <= 1'b1;
          dx        <= DIFF_W'(px) - DIFF_W'(lx);
          dy        <= DIFF_W'(py) - DIFF_W'(ly);
          spd       <= '0;
          cz        <= '0;
          state     <= seen[idx] ? S_SQX : S_DONE;
        end
        S_SQX: begin
          d2    <= mprod;
          state <= S_SQY;
        end
        S_SQY: begin
          d2    <= d2 + mprod;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= dbit ? INTV_W'(dshift - divisor) : dshift[INTV_W-1:0];
          d2  <= {d2[SQ_W-2:0], dbit};
          if (cnt == CNT_W'(SQ_W-1)) begin
            cnt   <= '0;
            root  <= '0;
            srem  <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          srem <= rbit ? rshift - rtrial : rshift;
          root <= {root[ROOT_W-2:0], rbit};
          d2   <= {d2[SQ_W-3:0], 2'b00};
          if (cnt == CNT_W'(ROOT_W-1)) begin
            cnt   <= '0;
            state <= S_CORD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CORD: begin
          if (cnt == '0 && spd == '0 && !first) begin
            // first cycle here: latch speed and, if it is nonzero, start the rotation
            spd <= root_sat;
            if (root_sat == '0) begin
              state <= S_DONE;
            end else if (dx[DIFF_W-1]) begin
              cx  <= -x0;
              cy  <= -y0;
              cz  <= DEG180;
              cnt <= '0;
            end else begin
              cx  <= x0;
              cy  <= y0;
              cz  <= '0;
              cnt <= '0;
            end
          end else begin
            if (cy >= 0) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + tab;
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - tab;
            end
            if (cnt == CNT_W'(CORDIC_STEPS-1)) begin
              cnt   <= '0;
              state <= S_DONE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, !first, (spd == '0) ? HEAD_W'(0) : hdg, spd, idx};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // cnt indexes the cordic table; spd marks the setup cycle
  // the setup cycle uses cnt 0 with spd still zero; the first rotation
  // (table entry 0) then runs at cnt 0 next, once spd is set
endmodule

FILE: sv/sht_checker.sv
`timescale 1ns / 1ps
module sht_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import sht_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[42:30] < HEADING_FULL)
    else $error("heading out of range");

  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[43] |-> m_tdata[42:6] == '0)
    else $error("first sample carries motion");

  a_still: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29:6] == '0 |-> m_tdata[42:30] == '0)
    else $error("heading without speed");
endmodule

bind speed_heading_tracker sht_props u_sht_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
